// ===== sv/qsed_pkg.sv =====
// types, codes and character helpers shared by the escape decoder
package qsed_pkg;

    typedef enum logic [2:0] {
        PH_OPEN   = 3'd0,
        PH_BODY   = 3'd1,
        PH_ESC    = 3'd2,
        PH_HEX_HI = 3'd3,
        PH_HEX_LO = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_OPEN  = 3'd1,
        ST_NO_CLOSE = 3'd2,
        ST_BAD_ESC  = 3'd3,
        ST_BAD_HEX  = 3'd4,
        ST_IN_ESC   = 3'd5
    } status_t;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] high_nibble;
        status_t    error_code;
    } state_t;

    localparam state_t STATE_RESET = '{phase: PH_OPEN, high_nibble: 4'd0, error_code: ST_OK};

    typedef struct packed {
        logic [7:0] byte_out;
        logic       end_of_string;
        status_t    status;
    } result_t;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        begin
            d = 8'd0;
            r = 5'd0;
            if (c >= CH_0 && c <= CH_9)
            begin
                d = c - CH_0;
                r = {1'b1, d[3:0]};
            end
            else if (c >= CH_LC_A && c <= CH_LC_F)
            begin
                d = c - CH_LC_A + HEX_TEN;
                r = {1'b1, d[3:0]};
            end
            else if (c >= CH_UC_A && c <= CH_UC_F)
            begin
                d = c - CH_UC_A + HEX_TEN;
                r = {1'b1, d[3:0]};
            end
            return r;
        end
    endfunction

    // {valid, byte} of a single-character escape
    function automatic logic [8:0] escape_value(input logic [7:0] c);
        logic [8:0] r;
        begin
            unique case (c)
                CH_0:      r = {1'b1, 8'h00};
                CH_SQUOTE: r = {1'b1, 8'h27};
                CH_DQUOTE: r = {1'b1, 8'h22};
                CH_BSLASH: r = {1'b1, 8'h5C};
                CH_N:      r = {1'b1, 8'h0A};
                CH_R:      r = {1'b1, 8'h0D};
                CH_T:      r = {1'b1, 8'h09};
                CH_B:      r = {1'b1, 8'h08};
                CH_F:      r = {1'b1, 8'h0C};
                CH_V:      r = {1'b1, 8'h0B};
                default:   r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/qsed_in_if.sv =====
// character channel of the escape decoder
interface qsed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink (input valid, input char_in, input is_last, output ready);
endinterface

// ===== sv/qsed_out_if.sv =====
// decoded byte channel of the escape decoder
interface qsed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       end_of_string;
    logic [2:0] status;

    modport source (output valid, output byte_out, output end_of_string, output status,
                    input ready);
    modport sink (input valid, input byte_out, input end_of_string, input status,
                  output ready);
endinterface

// ===== sv/qsed_decode.sv =====
// next-state and result logic for one character
module qsed_decode
    import qsed_pkg::*;
(
    input  state_t     st,
    input  logic [7:0] char_in,
    input  logic       is_last,
    output state_t     st_next,
    output logic       res_valid,
    output result_t    res
);

    logic [4:0] hex;
    logic [8:0] esc;

    assign hex = hex_value(char_in);
    assign esc = escape_value(char_in);

    always_comb
    begin
        st_next   = st;
        res_valid = 1'b0;
        res       = '{byte_out: 8'd0, end_of_string: 1'b0, status: ST_OK};

        if (is_last)
        begin
            res_valid         = 1'b1;
            res.end_of_string = 1'b1;
            st_next           = STATE_RESET;
            if (st.error_code != ST_OK)
                res.status = st.error_code;
            else if (st.phase == PH_OPEN)
                res.status = (char_in == CH_DQUOTE) ? ST_NO_CLOSE : ST_NO_OPEN;
            else if (st.phase == PH_ESC || st.phase == PH_HEX_HI || st.phase == PH_HEX_LO)
                res.status = ST_IN_ESC;
            else
                res.status = (char_in == CH_DQUOTE) ? ST_OK : ST_NO_CLOSE;
        end
        else if (st.error_code == ST_OK)
        begin
            unique case (st.phase)
                PH_OPEN:
                begin
                    if (char_in != CH_DQUOTE)
                        st_next.error_code = ST_NO_OPEN;
                    st_next.phase = PH_BODY;
                end
                PH_ESC:
                begin
                    if (char_in == CH_X)
                        st_next.phase = PH_HEX_HI;
                    else
                    begin
                        st_next.phase = PH_BODY;
                        if (esc[8])
                        begin
                            res_valid    = 1'b1;
                            res.byte_out = esc[7:0];
                        end
                        else
                            st_next.error_code = ST_BAD_ESC;
                    end
                end
                PH_HEX_HI:
                begin
                    if (hex[4])
                    begin
                        st_next.high_nibble = hex[3:0];
                        st_next.phase       = PH_HEX_LO;
                    end
                    else
                    begin
                        st_next.error_code = ST_BAD_HEX;
                        st_next.phase      = PH_BODY;
                    end
                end
                PH_HEX_LO:
                begin
                    st_next.phase = PH_BODY;
                    if (hex[4])
                    begin
                        res_valid           = 1'b1;
                        res.byte_out        = {st.high_nibble, hex[3:0]};
                        st_next.high_nibble = 4'd0;
                    end
                    else
                        st_next.error_code = ST_BAD_HEX;
                end
                default:
                begin
                    // body byte, also covers unused phase codes
                    if (char_in == CH_BSLASH)
                        st_next.phase = PH_ESC;
                    else
                    begin
                        st_next.phase = PH_BODY;
                        res_valid     = 1'b1;
                        res.byte_out  = char_in;
                    end
                end
            endcase
        end
    end

endmodule

// ===== sv/qsed_out_stage.sv =====
// result register driving the decoded byte channel
module qsed_out_stage
    import qsed_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    free,
    qsed_out_if.source decoded
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    assign free           = !out_valid_reg || decoded.ready;
    assign out_valid_next = load ? 1'b1 : (out_valid_reg && !decoded.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign decoded.valid         = out_valid_reg;
    assign decoded.byte_out      = res_reg.byte_out;
    assign decoded.end_of_string = res_reg.end_of_string;
    assign decoded.status        = res_reg.status;

endmodule

// ===== sv/quoted_string_escape_decoder.sv =====
// top level of the quoted string escape decoder
//
//  channel   role    payload                                 transfer when
//  text      sink    char_in[7:0], is_last                   text.valid && text.ready
//  decoded   source  byte_out[7:0], end_of_string, status    decoded.valid && decoded.ready
//
// one character a cycle sustained while decoded does not stall: a character is held
// in the input register, the decode logic updates the literal state and the result
// register in the same edge, and the result register drives decoded
// reset clears the valid flags and the literal state, so the next byte must open a literal
// a stall on decoded holds the input register once the result register is full; text.ready
// then follows decoded.ready in the same cycle
module quoted_string_escape_decoder
    import qsed_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    qsed_in_if.sink    text,
    qsed_out_if.source decoded
);

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] char_reg;
    logic       last_reg;

    // literal state
    state_t     state_reg;
    state_t     state_next;

    logic       res_valid;
    result_t    res;
    logic       out_free;
    logic       advance;
    logic       in_take;

    // the held character moves on whenever the result register can take it
    assign advance       = in_valid_reg && out_free;
    assign text.ready    = !in_valid_reg || out_free;
    assign in_take       = text.valid && text.ready;
    assign in_valid_next = in_take ? 1'b1 : (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= text.char_in;
            last_reg <= text.is_last;
        end
    end

    qsed_decode u_decode (
        .st        (state_reg),
        .char_in   (char_reg),
        .is_last   (last_reg),
        .st_next   (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // characters that produce nothing (escape lead-ins, errors) just update the state
    qsed_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance && res_valid),
        .res     (res),
        .free    (out_free),
        .decoded (decoded)
    );

endmodule

// ===== sv/qsed_checker.sv =====
// port checks for the escape decoder and their binding
module qsed_checker
    import qsed_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] byte_out,
    input logic       end_of_string,
    input logic [2:0] status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_out)
            && $stable(end_of_string) && $stable(status))
        else $error("decoded result changed while stalled");

    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_string |-> status == ST_OK)
        else $error("decoded byte carries a nonzero status");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> byte_out == 8'd0)
        else $error("end result carries a nonzero byte");

    a_end_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> status <= ST_IN_ESC)
        else $error("end result carries an undefined status");

endmodule

bind quoted_string_escape_decoder qsed_checker u_qsed_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (decoded.valid),
    .out_ready     (decoded.ready),
    .byte_out      (decoded.byte_out),
    .end_of_string (decoded.end_of_string),
    .status        (decoded.status)
);
